FILE: hdl/bts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bts_pkg
// shared types, constants and helpers of the block transfer sequencer
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int unsigned LIST_W  = 16;
  localparam int unsigned REG_W   = 4;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COUNT_W = 5;

  localparam logic [ADDR_W-1:0] WORD_BYTES = 32'd4;
  localparam logic [REG_W-1:0]  PC_REG     = 4'd15;

  typedef struct packed {
    logic [LIST_W-1:0] register_list;
    logic [REG_W-1:0]  base_register;
    logic [ADDR_W-1:0] base_value;
    logic              is_load;
    logic              write_back;
    logic              status_bit;
    logic              step_up;
    logic              pre_index;
  } bts_in_t;

  typedef struct packed {
    logic              transfer_valid;
    logic [ADDR_W-1:0] address;
    logic [REG_W-1:0]  reg_index;
    logic              read_not_write;
    logic              user_bank;
    logic              add_pc_offset;
    logic              writeback_enable;
    logic [ADDR_W-1:0] writeback_value;
    logic              flush_request;
    logic              restore_status;
    logic              undefined_instruction;
    logic              last;
  } bts_out_t;

  // lowest set bit of the remaining list
  typedef struct packed {
    logic              found;
    logic [REG_W-1:0]  idx;
    logic [LIST_W-1:0] rest;
    logic              rest_empty;
  } bts_scan_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPAN,
    ST_ORIGIN,
    ST_EMIT
  } bts_state_t;

  // adder tree population count of the register list
  function automatic logic [COUNT_W-1:0] popcount16(input logic [LIST_W-1:0] v);
    logic [1:0] s2 [8];
    logic [2:0] s4 [4];
    logic [3:0] s8 [2];
    for (int i = 0; i < 8; i++) begin
      s2[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      s4[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s8[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    end
    return {1'b0, s8[0]} + {1'b0, s8[1]};
  endfunction

endpackage : bts_pkg
`default_nettype wire

FILE: hdl/block_transfer_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_transfer_sequencer_top
// expands one load/store-multiple instruction into per-register memory beats
// ----------------------------------------------------------------------------
// sequence: the SPAN state forms the final base, ORIGIN the lowest address and
//   EMIT one registered beat per register; r15 as base ends in SPAN, an empty list in ORIGIN
// throughput: one beat per cycle in EMIT; a new instruction is taken only when
//   idle, busy stays high until the last beat; the shared adder steps the address
// reset: rst_n synchronous active low, returns the sequencer to idle and
//   drops the result strobe; the receiver cannot stall, beats are never held
// ----------------------------------------------------------------------------
module block_transfer_sequencer_top
  import bts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire bts_in_t  in_item,
  output logic          out_strobe,
  output bts_out_t      out_item
);

  // control state
  bts_state_t state_r, state_nxt;
  logic       strobe_r, strobe_nxt;

  // latched instruction and working registers
  bts_in_t           item_r;
  logic [LIST_W-1:0] list_r, list_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] wb_r, wb_nxt;
  bts_out_t          res_r, res_nxt;

  // shared adder operands
  logic [ADDR_W-1:0] alu_a, alu_b, alu_sum;
  logic              alu_sub;

  bts_scan_t         scan;
  logic [ADDR_W-1:0] span;

  // mode decode of the latched instruction
  logic pc_in, pc_load, userbank, wb_en, flush, restore;

  assign pc_in    = item_r.register_list[PC_REG];
  assign pc_load  = item_r.is_load & pc_in;
  // s bit with r15 loaded restores status, otherwise s bit selects user bank
  assign userbank = item_r.status_bit & ~pc_load;
  assign wb_en    = item_r.write_back & ~userbank;
  assign flush    = pc_load & ~userbank;
  assign restore  = pc_load & item_r.status_bit;

  // byte span of the whole block, four bytes a register
  assign span = ADDR_W'(popcount16(item_r.register_list)) << 2;

  bts_alu u_alu (
    .op_a (alu_a),
    .op_b (alu_b),
    .sub  (alu_sub),
    .sum  (alu_sum)
  );

  bts_scan u_scan (
    .list (list_r),
    .scan (scan)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SPAN;
        end
      end
      ST_SPAN: begin
        // a base of r15 ends here with the undefined beat
        state_nxt = (item_r.base_register == PC_REG) ? ST_IDLE : ST_ORIGIN;
      end
      ST_ORIGIN: begin
        state_nxt = scan.found ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (scan.rest_empty) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control and result assembly
  always_comb begin
    alu_a      = addr_r;
    alu_b      = '0;
    alu_sub    = 1'b0;
    list_nxt   = list_r;
    addr_nxt   = addr_r;
    wb_nxt     = wb_r;
    res_nxt    = res_r;
    strobe_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        list_nxt = in_item.register_list;
      end
      ST_SPAN: begin
        // final base: base plus or minus the span
        alu_a   = item_r.base_value;
        alu_b   = span;
        alu_sub = ~item_r.step_up;
        wb_nxt  = alu_sum;
        if (item_r.base_register == PC_REG) begin
          res_nxt                       = '0;
          res_nxt.undefined_instruction = 1'b1;
          res_nxt.last                  = 1'b1;
          strobe_nxt                    = 1'b1;
        end
      end
      ST_ORIGIN: begin
        // lowest address: ib base+4, ia base, db final, da final+4
        if (item_r.step_up) begin
          alu_a = item_r.base_value;
          alu_b = item_r.pre_index ? WORD_BYTES : '0;
        end else begin
          alu_a = wb_r;
          alu_b = item_r.pre_index ? '0 : WORD_BYTES;
        end
        addr_nxt = alu_sum;
        if (!scan.found) begin
          // empty list: one non-transfer beat with the block's side effects
          res_nxt                  = '0;
          res_nxt.writeback_enable = wb_en;
          res_nxt.writeback_value  = wb_en ? wb_r : '0;
          res_nxt.flush_request    = flush;
          res_nxt.restore_status   = restore;
          res_nxt.last             = 1'b1;
          strobe_nxt               = 1'b1;
        end
      end
      ST_EMIT: begin
        alu_a    = addr_r;
        alu_b    = WORD_BYTES;
        addr_nxt = alu_sum;
        list_nxt = scan.rest;
        res_nxt                       = '0;
        res_nxt.transfer_valid        = 1'b1;
        res_nxt.address               = addr_r;
        res_nxt.reg_index             = scan.idx;
        res_nxt.read_not_write        = item_r.is_load;
        res_nxt.user_bank             = userbank;
        res_nxt.add_pc_offset         = ~item_r.is_load & (scan.idx == PC_REG);
        res_nxt.undefined_instruction = 1'b0;
        res_nxt.last                  = scan.rest_empty;
        if (scan.rest_empty) begin
          res_nxt.writeback_enable = wb_en;
          res_nxt.writeback_value  = wb_en ? wb_r : '0;
          res_nxt.flush_request    = flush;
          res_nxt.restore_status   = restore;
        end
        strobe_nxt = 1'b1;
      end
      default: begin
        strobe_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      item_r <= in_item;
    end
    list_r <= list_nxt;
    addr_r <= addr_nxt;
    wb_r   <= wb_nxt;
    res_r  <= res_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;
  assign out_item   = res_r;

`ifndef SYNTHESIS
  // a beat that is not the last one leaves the sequencer still working
  a_more_beats_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.last) |-> busy)
    else $error("non-last beat while sequencer idle");

  // an accepted instruction occupies the sequencer in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("instruction accepted but sequencer not busy");

  // the undefined beat carries no transfer and ends the instruction
  a_undef_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.undefined_instruction) |->
      (out_item.last && !out_item.transfer_valid))
    else $error("undefined beat malformed");

  // side effects only on the final beat
  a_wb_last_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.last) |->
      (!out_item.writeback_enable && !out_item.flush_request &&
       !out_item.restore_status))
    else $error("writeback, flush or restore before the final beat");
`endif

endmodule : block_transfer_sequencer_top
`default_nettype wire

FILE: hdl/bts_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bts_alu
// shared 32-bit add/subtract unit for span, start and step addresses
// ----------------------------------------------------------------------------
module bts_alu
  import bts_pkg::*;
(
  input  wire logic [ADDR_W-1:0] op_a,
  input  wire logic [ADDR_W-1:0] op_b,
  input  wire logic              sub,
  output logic      [ADDR_W-1:0] sum
);

  logic [ADDR_W-1:0] b_eff;

  assign b_eff = sub ? ~op_b : op_b;
  assign sum   = op_a + b_eff + {{(ADDR_W-1){1'b0}}, sub};

endmodule : bts_alu
`default_nettype wire

FILE: hdl/bts_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bts_scan
// finds the lowest pending register of the list and the list without it
// ----------------------------------------------------------------------------
module bts_scan
  import bts_pkg::*;
(
  input  wire logic [LIST_W-1:0] list,
  output bts_scan_t              scan
);

  logic [REG_W-1:0]  idx;
  logic [LIST_W-1:0] onehot;

  always_comb begin
    idx    = '0;
    onehot = '0;
    for (int i = LIST_W - 1; i >= 0; i--) begin
      if (list[i]) begin
        idx    = REG_W'(i);
        onehot = LIST_W'(1) << i;
      end
    end
  end

  assign scan.found      = |list;
  assign scan.idx        = idx;
  assign scan.rest       = list & ~onehot;
  assign scan.rest_empty = ~|(list & ~onehot);

endmodule : bts_scan
`default_nettype wire
